/* src/fgce_pkg.sv */
// Falling glyph column engine: shared types and constants.
// Used by fgce_col_store, fgce_col_update, falling_glyph_column_engine_top and the testbench.
package fgce_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_DROP  = 2'd1,
    MODE_PAUSE = 2'd2,
    MODE_SLIDE = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [6:0]  head;
    logic [7:0]  timer;
    logic [2:0]  speed;
  } rec_t;

  // Cell overrides for the emit pass of one tick
  typedef struct packed {
    logic        fall_en;
    logic        bright;
    logic [6:0]  head;
    logic [2:0]  fall_n;
    logic [2:0]  fall_cnt;
    logic        stop_en;
    logic        slide_en;
    logic [2:0]  shift;
  } plan_t;

  localparam logic [6:0]  GLYPH_COUNT = 7'd80;
  localparam logic [6:0]  GLYPH_RESET = 7'd79;
  localparam logic [6:0]  ROWS_RESET  = 7'd60;
  localparam logic [6:0]  ROWS_MIN    = 7'd6;
  localparam logic [7:0]  LEVEL_STICKY = 8'd255;
  localparam logic [7:0]  LEVEL_HEAD  = 8'd254;
  localparam logic [12:0] DECAY_MUL   = 13'd6554;

endpackage

/* src/falling_glyph_column_engine_top.sv */
// Falling glyph column engine, top level.
// An item passes S_REC, then S_SLIDE for a slide, then S_EMIT, which issues one cell per
// cycle unless the output buffer is full; cells leave through the output register. No new item is
// taken until the emit pass ends; the grid memory port of the slide and emit passes is the limit.
// Reset: synchronous; a clearing pass over every grid entry (MAX_COLUMNS
// times MAX_ROWS rounded up to a power of two) runs while no item is accepted.
module falling_glyph_column_engine_top #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,  // column, rand_word, char_pick_0..char_pick_4, zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // cell_row, glyph_code, cell_level, zero fill
  output logic        m_tlast,  // last_cell
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int AW    = CW + RW;
  localparam int GDEPTH = MAX_COLUMNS * (2 ** RW);
  localparam logic [10:0] COL_LIMIT = 11'(MAX_COLUMNS);
  localparam logic [6:0]  ROWS_MAX  = 7'(MAX_ROWS);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_REC, S_SLIDE, S_EMIT} state_t;

  state_t state;
  logic [AW:0] clr_addr;
  logic [6:0]  rows_cfg;
  logic [6:0]  rows;
  logic [CW-1:0] col;
  logic [31:0] rnd;
  logic [6:0]  picks [5];
  fgce_pkg::plan_t plan;
  logic [6:0]  ycnt;
  logic [6:0]  srow;

  logic        sw_v;
  logic [6:0]  sw_row;
  logic        pend;
  logic [6:0]  pend_row;
  logic        out_v;
  logic [20:0] out_d;
  logic        out_l;
  logic        skid_v;
  logic [20:0] skid_d;
  logic        skid_l;

  fgce_pkg::rec_t rec_rd, rec_nxt, rec_wd;
  fgce_pkg::plan_t plan_nxt;
  logic          rec_we;
  logic [CW-1:0] rec_ra, rec_wa;

  logic [AW-1:0] g_ra, g_wa;
  logic [7:0]    g_rl, g_wl;
  logic [6:0]    g_rg, g_wg;
  logic          g_wel, g_weg;

  logic in_take, take, issue, col_ok;
  logic [1:0] occ;
  logic [11:0] dx;
  logic [24:0] dprod;
  logic [7:0]  lvl;
  logic [6:0]  gly;
  logic [6:0]  fj;
  logic [2:0]  fi;
  logic [2:0]  sidx;
  logic [20:0] arr_d;
  logic        arr_l;

  function automatic logic [6:0] glyph_wrap(input logic [6:0] p);
    return (p >= fgce_pkg::GLYPH_COUNT) ? p - fgce_pkg::GLYPH_COUNT : p;
  endfunction

  assign rows = (rows_cfg < fgce_pkg::ROWS_MIN) ? fgce_pkg::ROWS_MIN :
                (rows_cfg > ROWS_MAX) ? ROWS_MAX : rows_cfg;

  assign s_tready  = state == S_IDLE;
  assign cfg_ready = 1'b1;
  assign in_take   = s_tvalid && s_tready;
  assign col_ok    = {3'd0, s_tdata[7:0]} < COL_LIMIT;
  assign take      = out_v && m_tready;
  assign occ       = 2'(out_v) + 2'(skid_v) + 2'(pend) - 2'(take);
  assign issue     = (state == S_EMIT) && (occ < 2'd2);

  assign m_tvalid = out_v;
  assign m_tdata  = {3'd0, out_d};
  assign m_tlast  = out_l;

  fgce_col_store #(.DEPTH(MAX_COLUMNS), .AW(CW)) u_col (
    .clk(clk), .raddr(rec_ra), .rdata(rec_rd),
    .we(rec_we), .waddr(rec_wa), .wdata(rec_wd)
  );

  fgce_col_update u_upd (
    .cur(rec_rd), .rand_word(rnd), .rows(rows), .nxt(rec_nxt), .plan(plan_nxt)
  );

  fgce_grid_store #(.DEPTH(GDEPTH), .AW(AW)) u_grid (
    .clk(clk), .raddr(g_ra), .rlevel(g_rl), .rglyph(g_rg),
    .we_level(g_wel), .we_glyph(g_weg), .waddr(g_wa), .wlevel(g_wl), .wglyph(g_wg)
  );

  // column record port
  always_comb begin
    rec_ra = CW'(s_tdata[7:0]);
    rec_we = 1'b0;
    rec_wa = col;
    rec_wd = rec_nxt;
    if (state == S_CLEAR) begin
      rec_we = clr_addr < (AW+1)'(MAX_COLUMNS);
      rec_wa = clr_addr[CW-1:0];
      rec_wd = '0;
    end else if (state == S_REC) begin
      rec_we = 1'b1;
    end
  end

  // cell result for an arriving emit read
  always_comb begin
    dx    = {1'b0, g_rl, 3'd0} + {4'd0, g_rl};
    dprod = 25'(dx) * 25'(fgce_pkg::DECAY_MUL);
    lvl   = (g_rl == fgce_pkg::LEVEL_STICKY) ? g_rl : dprod[23:16];
    gly   = g_rg;
    fj    = pend_row - plan.head;
    fi    = plan.fall_n - fj[2:0];
    sidx  = plan.shift - 3'd1 - pend_row[2:0];
    if (plan.fall_en && pend_row >= plan.head && fj < {4'd0, plan.fall_cnt}) begin
      lvl = plan.bright ? fgce_pkg::LEVEL_STICKY :
            fgce_pkg::LEVEL_HEAD - ({2'd0, fi, 3'd0} + {4'd0, fi, 1'b0});
      gly = picks[fj[2:0]];
    end
    if (plan.stop_en && pend_row == plan.head) begin
      lvl = fgce_pkg::LEVEL_HEAD;
      gly = picks[0];
    end
    if (plan.slide_en && pend_row < {4'd0, plan.shift}) begin
      gly = picks[sidx];
    end
    arr_d = {lvl, gly, pend_row[5:0]};
    arr_l = (pend_row + 7'd1) == rows;
  end

  // grid ports
  always_comb begin
    srow  = ycnt - {4'd0, plan.shift};
    g_ra  = {col, ycnt[RW-1:0]};
    g_wa  = {col, pend_row[RW-1:0]};
    g_wl  = lvl;
    g_wg  = gly;
    g_wel = 1'b0;
    g_weg = 1'b0;
    if (state == S_SLIDE) begin
      g_ra = {col, srow[RW-1:0]};
    end
    if (state == S_CLEAR) begin
      g_wa  = clr_addr[AW-1:0];
      g_wl  = '0;
      g_wg  = fgce_pkg::GLYPH_RESET;
      g_wel = 1'b1;
      g_weg = 1'b1;
    end else if (sw_v) begin
      g_wa  = {col, sw_row[RW-1:0]};
      g_wg  = g_rg;
      g_weg = 1'b1;
    end else if (pend) begin
      g_wel = 1'b1;
      g_weg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      rows_cfg <= fgce_pkg::ROWS_RESET;
      sw_v     <= 1'b0;
      pend     <= 1'b0;
      out_v    <= 1'b0;
      skid_v   <= 1'b0;
      ycnt     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        rows_cfg <= cfg_data;
      end
      sw_v <= (state == S_SLIDE);
      pend <= issue;
      if (issue) begin
        pend_row <= ycnt;
      end

      if (take || !out_v) begin
        if (skid_v) begin
          out_d  <= skid_d;
          out_l  <= skid_l;
          skid_v <= pend;
          skid_d <= arr_d;
          skid_l <= arr_l;
        end else begin
          out_v <= pend;
          out_d <= arr_d;
          out_l <= arr_l;
        end
      end else if (pend) begin
        skid_v <= 1'b1;
        skid_d <= arr_d;
        skid_l <= arr_l;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + (AW+1)'(1);
          if (clr_addr == (AW+1)'(GDEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_take && col_ok) begin
            col   <= CW'(s_tdata[7:0]);
            rnd   <= s_tdata[39:8];
            picks[0] <= glyph_wrap(s_tdata[46:40]);
            picks[1] <= glyph_wrap(s_tdata[53:47]);
            picks[2] <= glyph_wrap(s_tdata[60:54]);
            picks[3] <= glyph_wrap(s_tdata[67:61]);
            picks[4] <= glyph_wrap(s_tdata[74:68]);
            state <= S_REC;
          end
        end
        S_REC: begin
          plan <= plan_nxt;
          if (plan_nxt.slide_en) begin
            ycnt  <= rows - 7'd1;
            state <= S_SLIDE;
          end else begin
            ycnt  <= '0;
            state <= S_EMIT;
          end
        end
        S_SLIDE: begin
          sw_row <= ycnt;
          if (ycnt == {4'd0, plan.shift}) begin
            ycnt  <= '0;
            state <= S_EMIT;
          end else begin
            ycnt <= ycnt - 7'd1;
          end
        end
        S_EMIT: begin
          if (issue) begin
            ycnt <= ycnt + 7'd1;
            if (ycnt == rows - 7'd1) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/fgce_col_store.sv */
// Column record memory, one record per column, registered read.
// Depends on fgce_pkg for the record type.
module fgce_col_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic [AW-1:0] raddr,
  output fgce_pkg::rec_t rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  fgce_pkg::rec_t wdata
);

  fgce_pkg::rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/fgce_grid_store.sv */
// Cell grid memory: level and glyph per cell, registered read.
// Standalone; addressed as {column, row}.
module fgce_grid_store #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rlevel,
  output logic [6:0]    rglyph,
  input  logic          we_level,
  input  logic          we_glyph,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wlevel,
  input  logic [6:0]    wglyph
);

  logic [7:0] level_mem [DEPTH];
  logic [6:0] glyph_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we_level) begin
      level_mem[waddr] <= wlevel;
    end
    if (we_glyph) begin
      glyph_mem[waddr] <= wglyph;
    end
    rlevel <= level_mem[raddr];
    rglyph <= glyph_mem[raddr];
  end

endmodule

/* src/fgce_col_update.sv */
// Mode record step for one column tick, plus the cell plan for the emit pass.
// Depends on fgce_pkg.
module fgce_col_update (
  input  fgce_pkg::rec_t  cur,
  input  logic [31:0]     rand_word,
  input  logic [6:0]      rows,
  output fgce_pkg::rec_t  nxt,
  output fgce_pkg::plan_t plan
);

  logic [2:0] n;
  logic       hin;
  logic [6:0] room;
  logic [2:0] cnt;
  logic [6:0] hend;
  logic       tpos;
  logic [7:0] t1;
  logic [7:0] tdec;
  logic       bottom;

  always_comb begin
    n      = (cur.speed > 3'd4) ? 3'd4 : cur.speed;
    hin    = cur.head < rows;
    room   = rows - cur.head;
    cnt    = hin ? ((room < {4'd0, n}) ? room[2:0] : n) : 3'd0;
    hend   = cur.head + {4'd0, cnt};
    tpos   = !cur.timer[7] && (cur.timer != 8'd0);
    t1     = tpos ? cur.timer - 8'd1 : cur.timer;
    tdec   = cur.timer - 8'd1;
    bottom = hend >= rows;

    nxt  = cur;
    plan = '0;
    plan.head = cur.head;

    unique case (cur.mode)
      fgce_pkg::MODE_IDLE: begin
        if (rand_word[7:4] == 4'hf) begin
          nxt.mode  = fgce_pkg::MODE_DROP;
          nxt.head  = 7'd0;
          nxt.speed = {1'b0, rand_word[31:30]} + 3'd1;
          nxt.timer = 8'd0;
        end else if (rand_word[15:12] == 4'hf) begin
          nxt.mode  = fgce_pkg::MODE_SLIDE;
          nxt.timer = {4'd0, rand_word[31:28]} + 8'd15;
          nxt.speed = {1'b0, rand_word[25:24]} + 3'd2;
        end
      end
      fgce_pkg::MODE_DROP: begin
        plan.fall_en  = 1'b1;
        plan.bright   = tpos;
        plan.fall_n   = n;
        plan.fall_cnt = cnt;
        nxt.timer = t1;
        nxt.head  = hend;
        nxt.mode  = bottom ? fgce_pkg::MODE_IDLE : fgce_pkg::MODE_DROP;
        if (t1 == 8'd0) begin
          if (rand_word[13:8] == 6'h3f) begin
            nxt.timer = {4'd0, rand_word[31:28]} + 8'd8;
          end else if (!bottom && cur.speed > 3'd1 && rand_word[6:0] == 7'h7f) begin
            nxt.mode  = fgce_pkg::MODE_PAUSE;
            nxt.timer = {2'd0, rand_word[31:26]} + 8'd30;
          end
        end
      end
      fgce_pkg::MODE_PAUSE: begin
        plan.stop_en = hin;
        nxt.timer = tdec;
        if (tdec[7]) begin
          nxt.mode = fgce_pkg::MODE_DROP;
        end
      end
      fgce_pkg::MODE_SLIDE: begin
        plan.shift    = (cur.speed > 3'd5) ? 3'd5 : cur.speed;
        plan.slide_en = plan.shift != 3'd0;
        nxt.timer = tdec;
        if (tdec[7]) begin
          nxt.mode = fgce_pkg::MODE_IDLE;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

/* dv/testbench.sv */
// Testbench for falling_glyph_column_engine_top: streams column ticks and
// checks every emitted cell against an in-bench model of the glyph grid.
// Depends on fgce_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module testbench;

  localparam int NCOL = 256;
  localparam int NROW = 64;
  localparam int IDLE_CYCLES = 80;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [6:0]  pick4;
    logic [6:0]  pick3;
    logic [6:0]  pick2;
    logic [6:0]  pick1;
    logic [6:0]  pick0;
    logic [31:0] rword;
    logic [7:0]  col;
  } tick_t;

  typedef struct packed {
    logic [5:0] row;
    logic [6:0] glyph;
    logic [7:0] level;
    logic       last;
  } cell_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_data;

  falling_glyph_column_engine_top i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // model state
  logic [6:0]       rows_reg;
  fgce_pkg::mode_t  mdl_mode [NCOL];
  logic [6:0]       mdl_head [NCOL];
  logic [7:0]       mdl_timer [NCOL];
  logic [2:0]       mdl_speed [NCOL];
  logic [7:0]       lvl_grid [NCOL][NROW];
  logic [6:0]       gly_grid [NCOL][NROW];

  tick_t pending_ticks[$];
  cell_t expected_cells[$];
  int    mismatches = 0;
  int    cells_seen = 0;
  int    ticks_sent = 0;
  int    cycles = 0;
  logic  quiet;
  logic  hold_send;

  function automatic logic [6:0] fold_glyph(logic [6:0] g);
    return (g >= fgce_pkg::GLYPH_COUNT) ? g - fgce_pkg::GLYPH_COUNT : g;
  endfunction

  task automatic grid_reset();
    rows_reg = fgce_pkg::ROWS_RESET;
    for (int c = 0; c < NCOL; c++) begin
      mdl_mode[c] = fgce_pkg::MODE_IDLE;
      mdl_head[c] = '0;
      mdl_timer[c] = '0;
      mdl_speed[c] = '0;
      for (int y = 0; y < NROW; y++) begin
        lvl_grid[c][y] = '0;
        gly_grid[c][y] = fgce_pkg::GLYPH_RESET;
      end
    end
  endtask

  task automatic tick_column(tick_t t);
    int rows, x, h, n, used, s;
    logic [6:0] pk[5];
    logic [31:0] r;
    logic bottom;
    cell_t c;
    rows = rows_reg < 6 ? 6 : (rows_reg > NROW ? NROW : rows_reg);
    x = t.col;
    r = t.rword;
    pk[0] = fold_glyph(t.pick0);
    pk[1] = fold_glyph(t.pick1);
    pk[2] = fold_glyph(t.pick2);
    pk[3] = fold_glyph(t.pick3);
    pk[4] = fold_glyph(t.pick4);
    for (int y = 0; y < rows; y++)
      if (lvl_grid[x][y] != 8'd255) lvl_grid[x][y] = 8'((int'(lvl_grid[x][y]) * 9) / 10);
    case (mdl_mode[x])
      fgce_pkg::MODE_IDLE: begin
        if ((r & 32'hf0) == 32'hf0) begin
          mdl_mode[x] = fgce_pkg::MODE_DROP;
          mdl_head[x] = '0;
          mdl_speed[x] = 3'((r >> 30) + 1);
          mdl_timer[x] = '0;
        end else if ((r & 32'hf000) == 32'hf000) begin
          mdl_mode[x] = fgce_pkg::MODE_SLIDE;
          mdl_timer[x] = 8'((r >> 28) + 15);
          mdl_speed[x] = 3'(((r >> 24) & 3) + 2);
        end
      end
      fgce_pkg::MODE_DROP: begin
        h = mdl_head[x];
        n = mdl_speed[x];
        used = 0;
        if (n > 4) n = 4;
        while (n > 0 && h < rows) begin
          lvl_grid[x][h] = ($signed(mdl_timer[x]) > 0) ? 8'd255 : 8'(254 - n * 10);
          gly_grid[x][h] = pk[used];
          used++;
          h++;
          n--;
        end
        if ($signed(mdl_timer[x]) > 0) mdl_timer[x] = mdl_timer[x] - 8'd1;
        bottom = (h >= rows);
        if (bottom) mdl_mode[x] = fgce_pkg::MODE_IDLE;
        mdl_head[x] = h[6:0];
        if (mdl_timer[x] == 8'd0) begin
          if ((r & 32'h3f00) == 32'h3f00) begin
            mdl_timer[x] = 8'((r >> 28) + 8);
          end else if (!bottom && mdl_speed[x] > 3'd1 && (r & 32'h7f) == 32'h7f) begin
            mdl_mode[x] = fgce_pkg::MODE_PAUSE;
            mdl_timer[x] = 8'((r >> 26) + 30);
          end
        end
      end
      fgce_pkg::MODE_PAUSE: begin
        h = mdl_head[x];
        if (h < rows) begin
          lvl_grid[x][h] = fgce_pkg::LEVEL_HEAD;
          gly_grid[x][h] = pk[0];
        end
        mdl_timer[x] = mdl_timer[x] - 8'd1;
        if ($signed(mdl_timer[x]) < 0) mdl_mode[x] = fgce_pkg::MODE_DROP;
      end
      default: begin
        s = mdl_speed[x];
        mdl_timer[x] = mdl_timer[x] - 8'd1;
        if ($signed(mdl_timer[x]) < 0) mdl_mode[x] = fgce_pkg::MODE_IDLE;
        if (s > 5) s = 5;
        if (s > rows) s = rows;
        for (int y = rows; y > s; y--) gly_grid[x][y - 1] = gly_grid[x][y - 1 - s];
        for (int k = 0; k < s; k++) gly_grid[x][s - 1 - k] = pk[k];
      end
    endcase
    for (int y = 0; y < rows; y++) begin
      c.row = 6'(y);
      c.glyph = gly_grid[x][y];
      c.level = lvl_grid[x][y];
      c.last = (y + 1 == rows);
      expected_cells.push_back(c);
    end
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // idle pattern: 13% random gaps except during quiet stretch
  function automatic logic gap();
    return !quiet && ($urandom_range(99) < 13);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        tick_column(pending_ticks.pop_front());
        ticks_sent <= ticks_sent + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_ticks.size() != 0 && !hold_send && !gap()) begin
          s_tvalid <= 1;
          s_tdata <= 80'(pending_ticks[0]);
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cell_t got, want;
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[5:0], m_tdata[12:6], m_tdata[20:13], m_tlast};
        cells_seen <= cells_seen + 1;
        if (expected_cells.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected cell %h", m_tdata);
        end else begin
          want = expected_cells.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"cell mismatch: exp row %0d glyph %0d level %0d last %0d, ",
                        "got row %0d glyph %0d level %0d last %0d"},
                       want.row, want.glyph, want.level, want.last,
                       got.row, got.glyph, got.level, got.last);
          end
        end
      end
      m_tready <= !gap();
    end
  end

  function automatic tick_t rand_tick(int col_max);
    tick_t t;
    logic [31:0] r;
    int sel;
    r = $urandom();
    sel = $urandom_range(9);
    // bias toward the mode triggers so fall, stop and slide are reached
    if (sel < 3) r[7:4] = 4'hf;
    if (sel == 3 || sel == 4) r[15:12] = 4'hf;
    if (sel == 5) r[13:8] = 6'h3f;
    if (sel == 6) r[6:0] = 7'h7f;
    t.col = 8'($urandom_range(col_max));
    t.rword = r;
    t.pick0 = 7'($urandom_range(127));
    t.pick1 = 7'($urandom_range(127));
    t.pick2 = 7'($urandom_range(127));
    t.pick3 = 7'($urandom_range(127));
    t.pick4 = 7'($urandom_range(127));
    return t;
  endfunction

  task automatic drain();
    while (pending_ticks.size() != 0 || expected_cells.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rows(logic [6:0] v);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    rows_reg = v;
  endtask

  initial begin
    tick_t t;
    logic [6:0] row_set[5];
    row_set = '{7'd6, 7'd64, 7'd0, 7'd127, 7'd23};
    rst = 1;
    quiet = 0;
    hold_send = 0;
    s_tvalid = 0;
    s_tdata = '0;
    m_tready = 0;
    cfg_valid = 0;
    cfg_data = 0;
    grid_reset();
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed: extremes, each mode path
    t = '{pick4: 7'd127, pick3: 7'd80, pick2: 7'd79, pick1: 7'd0, pick0: 7'd127,
          rword: 32'hffffffff, col: 8'd255};
    pending_ticks.push_back(t);
    for (int i = 0; i < 12; i++) begin
      t.col = 8'd0;
      t.rword = (i == 0) ? 32'h400000f0 : ((i == 3) ? 32'h0000007f : 32'h0);
      t.pick0 = 7'(i * 7);
      pending_ticks.push_back(t);
    end
    t.col = 8'd1; t.rword = 32'hf300f000; pending_ticks.push_back(t);
    for (int i = 0; i < 6; i++) begin
      t.rword = 32'h0; pending_ticks.push_back(t);
    end
    t.col = 8'd2; t.rword = 32'hc00000f0; pending_ticks.push_back(t);
    t.rword = 32'hf0003f00; pending_ticks.push_back(t);
    t.rword = 32'h0; pending_ticks.push_back(t);
    t.col = 8'd0; t.rword = 32'h00000000; pending_ticks.push_back(t);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_rows(row_set[ph]);
      quiet = (ph == 1);
      for (int i = 0; i < 90; i++)
        pending_ticks.push_back(rand_tick(ph == 4 ? 255 : 7));
      if (ph == 2) begin
        // sender waits until every expected cell has arrived
        while (pending_ticks.size() > 45) @(posedge clk);
        hold_send = 1;
        while (expected_cells.size() != 0) @(posedge clk);
        hold_send = 0;
      end
      drain();
    end

    $display("ran %0d column ticks, checked %0d cells across 6 row settings",
             ticks_sent, cells_seen);
    if (mismatches == 0 && expected_cells.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
